FILE: hw/rtl/ghsl_pkg.sv
// ----------------------------------------------------------------------------
// ghsl_pkg
// Shared types and constants of the GNU hash symbol lookup core.
// ----------------------------------------------------------------------------
package ghsl_pkg;

  localparam int BLOOM_WORDS_DEF  = 64;
  localparam int BUCKETS_DEF      = 1024;
  localparam int SYMBOLS_DEF      = 4096;
  localparam int STRTAB_BYTES_DEF = 65536;
  localparam int MAX_NAME_DEF     = 64;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [31:0] HASH_SEED = 32'd5381;

  localparam logic [2:0] OP_BLOOM  = 3'd0;
  localparam logic [2:0] OP_BUCKET = 3'd1;
  localparam logic [2:0] OP_CHAIN  = 3'd2;
  localparam logic [2:0] OP_SYMBOL = 3'd3;
  localparam logic [2:0] OP_STRING = 3'd4;
  localparam logic [2:0] OP_KEY    = 3'd5;

  localparam logic [1:0] CFG_BUCKET_COUNT = 2'd0;
  localparam logic [1:0] CFG_FIRST_HASHED = 2'd1;
  localparam logic [1:0] CFG_BLOOM_WORDS  = 2'd2;
  localparam logic [1:0] CFG_BLOOM_SHIFT  = 2'd3;

  typedef struct packed {
    logic [10:0] bucket_count;
    logic [11:0] first_hashed;
    logic [6:0]  bloom_word_count;
    logic [4:0]  bloom_shift;
  } cfg_t;

  // One classified item on its way to the back end
  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] index;      // store address, or name position for key bytes
    logic [63:0] data;
    logic [15:0] str_offset;
    logic        key_we;     // key byte fits in the name buffer
    logic        last;       // key byte ends the name: run the lookup
    logic        overflow;
    logic [8:0]  key_len;    // name length including this byte
    logic [31:0] hash;       // hash including this byte
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_BLOOM,
    S_MOD,
    S_BUCKET,
    S_CHAIN_RD,
    S_CHAIN_CHK,
    S_CMP_RD,
    S_CMP_CHK,
    S_DONE
  } state_t;

endpackage

FILE: hw/rtl/ghsl_front.sv
// ----------------------------------------------------------------------------
// ghsl_front
// Accepts items, hashes key bytes and classifies items into commands.
// ----------------------------------------------------------------------------
module ghsl_front #(
  parameter int MAX_NAME = ghsl_pkg::MAX_NAME_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2:0]      op,
  input  logic [15:0]     index,
  input  logic [63:0]     data,
  input  logic [15:0]     str_offset,
  input  logic [7:0]      key_byte,
  input  logic            key_last,
  input  logic            q_full,
  output logic            q_push,
  output ghsl_pkg::cmd_t  q_cmd
);
  import ghsl_pkg::*;

  logic [31:0] hash;
  logic [8:0]  len;
  logic        ovf;
  logic        accept;
  logic        is_key;
  logic        fits;
  logic [31:0] hash_next;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign is_key    = (op == OP_KEY);
  assign fits      = (32'(len) < MAX_NAME);
  assign hash_next = (hash << 5) + hash + {24'd0, key_byte};
  // drop unused op codes here
  assign q_push    = accept && (op <= OP_KEY);

  always_comb begin
    q_cmd            = '0;
    q_cmd.op         = op;
    q_cmd.index      = is_key ? 16'(len) : index;
    q_cmd.data       = is_key ? {56'd0, key_byte} : data;
    q_cmd.str_offset = str_offset;
    q_cmd.key_we     = is_key && fits;
    q_cmd.last       = is_key && key_last;
    q_cmd.overflow   = ovf || !fits;
    q_cmd.key_len    = fits ? len + 9'd1 : len;
    q_cmd.hash       = hash_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= HASH_SEED;
      len  <= '0;
      ovf  <= 1'b0;
    end else if (accept && is_key) begin
      if (key_last) begin
        hash <= HASH_SEED;
        len  <= '0;
        ovf  <= 1'b0;
      end else begin
        hash <= hash_next;
        if (fits) begin
          len <= len + 9'd1;
        end else begin
          ovf <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/ghsl_queue.sv
// ----------------------------------------------------------------------------
// ghsl_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module ghsl_queue #(
  parameter int DEPTH = ghsl_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ghsl_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output ghsl_pkg::cmd_t head
);
  import ghsl_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full  = (32'(count) == DEPTH);
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

FILE: hw/rtl/ghsl_back.sv
// ----------------------------------------------------------------------------
// ghsl_back
// Owns the stores, carries out loads and runs the bloom, bucket and chain
// lookup with name compare.
// ----------------------------------------------------------------------------
module ghsl_back #(
  parameter int BLOOM_WORDS  = ghsl_pkg::BLOOM_WORDS_DEF,
  parameter int BUCKETS      = ghsl_pkg::BUCKETS_DEF,
  parameter int SYMBOLS      = ghsl_pkg::SYMBOLS_DEF,
  parameter int STRTAB_BYTES = ghsl_pkg::STRTAB_BYTES_DEF,
  parameter int MAX_NAME     = ghsl_pkg::MAX_NAME_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  ghsl_pkg::cfg_t cfg,
  input  logic           cmd_valid,
  input  ghsl_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           found,
  output logic [63:0]    symbol_value,
  output logic [31:0]    name_hash,
  output logic           name_too_long
);
  import ghsl_pkg::*;

  localparam int BW_AW = (BLOOM_WORDS > 1) ? $clog2(BLOOM_WORDS) : 1;
  localparam int BK_AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SY_AW = $clog2(SYMBOLS);
  localparam int ST_AW = $clog2(STRTAB_BYTES);
  localparam int NM_AW = $clog2(MAX_NAME);

  logic [63:0] bloom_mem  [BLOOM_WORDS];
  logic [12:0] bucket_mem [BUCKETS];
  logic [31:0] chain_mem  [SYMBOLS];
  logic [15:0] off_mem    [SYMBOLS];
  logic [63:0] val_mem    [SYMBOLS];
  logic [7:0]  str_mem    [STRTAB_BYTES];
  logic [7:0]  name_mem   [MAX_NAME];

  logic [63:0] bloom0;
  logic [63:0] bloom_rd;
  logic [12:0] bucket_rd;
  logic [31:0] chain_rd;
  logic [15:0] off_rd;
  logic [63:0] val_rd;
  logic [7:0]  str_rd;
  logic [7:0]  name_rd;

  state_t      state, state_next;
  logic [31:0] hash;
  logic        ovf;
  logic [8:0]  len;
  logic [11:0] rem;
  logic [4:0]  mod_cnt;
  logic [16:0] sym_i;
  logic        end_bit;
  logic [15:0] cmp_off;
  logic [8:0]  cmp_k;
  logic [63:0] cand_val;
  logic        res_found;
  logic        res_load;

  logic [10:0] nb;
  logic [6:0]  bloom_w;
  logic        bloom_used;
  logic        bloom_hit;
  logic [11:0] trial;
  logic [11:0] rem_next;
  logic [16:0] chain_idx;
  logic [31:0] pos;
  logic        cand_fail;
  logic        lookup_cmd;

  assign nb         = (cfg.bucket_count == '0) ? 11'd1 : cfg.bucket_count;
  assign bloom_w    = hash[12:6] & (cfg.bloom_word_count - 7'd1);
  assign bloom_used = (cfg.bloom_word_count != 7'd1) || (bloom0 != '0);
  assign bloom_hit  = bloom_rd[hash[5:0]] && bloom_rd[(hash >> cfg.bloom_shift) & 32'd63];
  assign trial      = {rem[10:0], hash[5'd31 - mod_cnt]};
  assign rem_next   = (trial >= {1'b0, nb}) ? trial - {1'b0, nb} : trial;
  assign chain_idx  = sym_i - {5'd0, cfg.first_hashed};
  assign pos        = 32'(cmp_off) + 32'(cmp_k);
  assign cmd_pop    = (state == S_IDLE) && cmd_valid;
  assign lookup_cmd = (cmd.op == OP_KEY) && cmd.last;
  assign res_load   = (state == S_DONE) && (!out_valid || out_ready);

  // Store writes
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      case (cmd.op)
        OP_BLOOM: begin
          if (32'(cmd.index) < BLOOM_WORDS) begin
            bloom_mem[BW_AW'(cmd.index)] <= cmd.data;
          end
          if (cmd.index == '0) begin
            bloom0 <= cmd.data;
          end
        end
        OP_BUCKET: begin
          if (32'(cmd.index) < BUCKETS) begin
            bucket_mem[BK_AW'(cmd.index)] <= cmd.data[12:0];
          end
        end
        OP_CHAIN: begin
          if (32'(cmd.index) < SYMBOLS) begin
            chain_mem[SY_AW'(cmd.index)] <= cmd.data[31:0];
          end
        end
        OP_SYMBOL: begin
          if (32'(cmd.index) < SYMBOLS) begin
            val_mem[SY_AW'(cmd.index)] <= cmd.data;
            off_mem[SY_AW'(cmd.index)] <= cmd.str_offset;
          end
        end
        OP_STRING: begin
          if (32'(cmd.index) < STRTAB_BYTES) begin
            str_mem[ST_AW'(cmd.index)] <= cmd.data[7:0];
          end
        end
        OP_KEY: begin
          if (cmd.key_we) begin
            name_mem[NM_AW'(cmd.index)] <= cmd.data[7:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Registered store reads
  always_ff @(posedge clk) begin
    bloom_rd  <= bloom_mem[BW_AW'(bloom_w)];
    bucket_rd <= bucket_mem[BK_AW'(rem_next)];
    chain_rd  <= chain_mem[SY_AW'(chain_idx)];
    off_rd    <= off_mem[SY_AW'(sym_i)];
    val_rd    <= val_mem[SY_AW'(sym_i)];
    str_rd    <= str_mem[ST_AW'(pos)];
    name_rd   <= name_mem[NM_AW'(cmp_k)];
  end

  always_comb begin
    cand_fail = 1'b0;
    case (state)
      S_CMP_RD:  cand_fail = (pos >= STRTAB_BYTES);
      S_CMP_CHK: cand_fail = (cmp_k < len) ? (str_rd != name_rd) : (str_rd != 8'd0);
      default:   cand_fail = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_pop && lookup_cmd) state_next = S_START;
      end
      S_START: begin
        if (ovf) state_next = S_DONE;
        else if (!bloom_used) state_next = S_MOD;
        else if (32'(bloom_w) >= BLOOM_WORDS) state_next = S_DONE;
        else state_next = S_BLOOM;
      end
      S_BLOOM: state_next = bloom_hit ? S_MOD : S_DONE;
      S_MOD: begin
        if (mod_cnt == 5'd31) state_next = S_BUCKET;
      end
      S_BUCKET: begin
        if (32'(rem) >= BUCKETS || bucket_rd < {1'b0, cfg.first_hashed}) state_next = S_DONE;
        else state_next = S_CHAIN_RD;
      end
      S_CHAIN_RD: begin
        if (32'(sym_i) >= SYMBOLS || 32'(chain_idx) >= SYMBOLS) state_next = S_DONE;
        else state_next = S_CHAIN_CHK;
      end
      S_CHAIN_CHK: begin
        if (chain_rd[31:1] == hash[31:1]) state_next = S_CMP_RD;
        else if (chain_rd[0]) state_next = S_DONE;
        else state_next = S_CHAIN_RD;
      end
      S_CMP_RD: begin
        if (cand_fail) state_next = end_bit ? S_DONE : S_CHAIN_RD;
        else state_next = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (cand_fail) state_next = end_bit ? S_DONE : S_CHAIN_RD;
        else if (cmp_k < len) state_next = S_CMP_RD;
        else state_next = S_DONE;
      end
      S_DONE: begin
        if (res_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Lookup datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        res_found <= 1'b0;
        if (cmd_pop && lookup_cmd) begin
          hash <= cmd.hash;
          ovf  <= cmd.overflow;
          len  <= cmd.key_len;
        end
      end
      S_START: begin
        rem     <= '0;
        mod_cnt <= '0;
      end
      S_MOD: begin
        rem     <= rem_next;
        mod_cnt <= mod_cnt + 5'd1;
      end
      S_BUCKET: sym_i <= {4'd0, bucket_rd};
      S_CHAIN_CHK: begin
        end_bit  <= chain_rd[0];
        cmp_off  <= off_rd;
        cand_val <= val_rd;
        cmp_k    <= '0;
        if (chain_rd[31:1] != hash[31:1]) sym_i <= sym_i + 17'd1;
      end
      S_CMP_RD: begin
        if (cand_fail) sym_i <= sym_i + 17'd1;
      end
      S_CMP_CHK: begin
        if (cand_fail) begin
          sym_i <= sym_i + 17'd1;
        end else if (cmp_k < len) begin
          cmp_k <= cmp_k + 9'd1;
        end else begin
          res_found <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      found         <= res_found;
      symbol_value  <= res_found ? cand_val : 64'd0;
      name_hash     <= hash;
      name_too_long <= ovf;
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> state == S_IDLE)
    else $error("command popped during a lookup");
  a_found_short: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> !name_too_long)
    else $error("overlong name reported as found");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> symbol_value == 64'd0)
    else $error("miss carries a symbol value");
  a_cmp_range: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP_CHK |-> cmp_k <= len)
    else $error("name compare ran past the key");
  a_mod_range: assert property (@(posedge clk) disable iff (rst)
    state == S_BUCKET |-> rem < {1'b0, nb})
    else $error("bucket remainder out of range");

endmodule

FILE: hw/rtl/gnu_hash_symbol_lookup_core.sv
// ----------------------------------------------------------------------------
// gnu_hash_symbol_lookup_core
// Symbol lookup through a GNU-style hash table with a 64-bit bloom filter.
// ----------------------------------------------------------------------------
// Loads and key bytes are accepted one per cycle into a four-entry queue and
// carried out in order by the back end, which pops none during a lookup.
// The last key byte starts a lookup that holds the back end through a start
// step, the bloom test (when in use), the bit-serial bucket remainder (one bit
// a cycle), the bucket read, a read and check per chain entry, per name byte
// and for the closing NUL, and posting the result. Input stalls only when the
// queue is full. No clearing pass: stores hold garbage until loaded.
module gnu_hash_symbol_lookup_core #(
  parameter int BLOOM_WORDS  = ghsl_pkg::BLOOM_WORDS_DEF,
  parameter int BUCKETS      = ghsl_pkg::BUCKETS_DEF,
  parameter int SYMBOLS      = ghsl_pkg::SYMBOLS_DEF,
  parameter int STRTAB_BYTES = ghsl_pkg::STRTAB_BYTES_DEF,
  parameter int MAX_NAME     = ghsl_pkg::MAX_NAME_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [15:0] index,
  input  logic [63:0] data,
  input  logic [15:0] str_offset,
  input  logic [7:0]  key_byte,
  input  logic        key_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [63:0] symbol_value,
  output logic [31:0] name_hash,
  output logic        name_too_long
);
  import ghsl_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t head;
  logic q_full;
  logic q_push;
  logic q_valid;
  logic q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bucket_count     <= 11'd1;
      cfg.first_hashed     <= '0;
      cfg.bloom_word_count <= 7'd1;
      cfg.bloom_shift      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BUCKET_COUNT: cfg.bucket_count     <= cfg_data[10:0];
        CFG_FIRST_HASHED: cfg.first_hashed     <= cfg_data;
        CFG_BLOOM_WORDS:  cfg.bloom_word_count <= cfg_data[6:0];
        CFG_BLOOM_SHIFT:  cfg.bloom_shift      <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  ghsl_front #(.MAX_NAME(MAX_NAME)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .index      (index),
    .data       (data),
    .str_offset (str_offset),
    .key_byte   (key_byte),
    .key_last   (key_last),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  ghsl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head)
  );

  ghsl_back #(
    .BLOOM_WORDS  (BLOOM_WORDS),
    .BUCKETS      (BUCKETS),
    .SYMBOLS      (SYMBOLS),
    .STRTAB_BYTES (STRTAB_BYTES),
    .MAX_NAME     (MAX_NAME)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd_valid     (q_valid),
    .cmd           (head),
    .cmd_pop       (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found         (found),
    .symbol_value  (symbol_value),
    .name_hash     (name_hash),
    .name_too_long (name_too_long)
  );

endmodule
